>>> rtl/rzs_pkg.sv
package rzs_pkg;

    // default sizing
    localparam int DEF_MAX_WINDOW = 64;
    localparam int DEF_PRICE_BITS = 24;

    // configuration register indexes
    localparam logic [2:0] CFG_WINDOW_LENGTH = 3'd0;
    localparam logic [2:0] CFG_EXTREME_Z     = 3'd1;
    localparam logic [2:0] CFG_MODERATE_Z    = 3'd2;
    localparam logic [2:0] CFG_CALM_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_CHOPPY_WIDTH  = 3'd4;
    localparam logic [2:0] CFG_MOMENTUM_BAND = 3'd5;

    // configuration reset values
    localparam logic [6:0]  RST_WINDOW_LENGTH = 7'd20;
    localparam logic [14:0] RST_EXTREME_Z     = 15'd10240;
    localparam logic [14:0] RST_MODERATE_Z    = 15'd6144;
    localparam logic [15:0] RST_CALM_WIDTH    = 16'd82;
    localparam logic [15:0] RST_CHOPPY_WIDTH  = 16'd123;
    localparam logic [15:0] RST_MOMENTUM_BAND = 16'd655;

    // q0.16 constants
    localparam logic [15:0] CONF_CAP  = 16'd62259;
    localparam logic [15:0] CONF_CALM = 16'd42598;
    localparam logic [15:0] CONF_HALF = 16'd32768;
    localparam logic [12:0] FRAC_MIN  = 13'd655;
    localparam logic [12:0] FRAC_MAX  = 13'd5242;

    typedef enum logic [1:0] {
        SIG_HOLD = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } sig_code_t;

endpackage

>>> rtl/rzs_div.sv
module rzs_div #(
    parameter int DVW = 44,
    parameter int DSW = 30
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [DVW-1:0] dividend,
    input  logic [DSW-1:0] divisor,
    output logic           busy,
    output logic           done,
    output logic [DVW-1:0] quotient
);

    localparam int CNTW = $clog2(DVW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [DVW-1:0]  quo_reg;
    logic [DSW-1:0]  rem_reg;
    logic [DSW-1:0]  den_reg;
    logic [DSW:0]    rem_sh;
    logic            fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg, quo_reg[DVW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == CNTW'(DVW-1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cnt_reg <= '0;
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            quo_reg <= {quo_reg[DVW-2:0], fits};
            if (fits)
            begin
                rem_reg <= DSW'(rem_sh - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= rem_sh[DSW-1:0];
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/rolling_zscore_signal_core.sv
// Rolling z-score signal core. Each price request (integer ticks, nonzero) goes into a ring
// of the last MAX_WINDOW prices; series_start clears the history first. Over the last
// N = window_length samples (clamped to 2..MAX_WINDOW) the core forms the sum and the sum
// of squares, D = N*sumsq - sum^2 and S = floor(sqrt(D)), then z = (N*p - sum)*4096/S,
// band width = 16384*S/sum and momentum against the price three samples back, and gives one
// result request: BUY, SELL or HOLD with confidence, saturated z and width, and a
// half-Kelly position fraction. Until N samples of the series have arrived the result is
// HOLD with all fields zero. One item is worked at a time: in_stall stays high from
// acceptance until the result is placed in the output register, and a waiting result
// does not block the next item. An item walks the ring, at least four entries,
// through the one shared multiplier, forms D, takes the bit-serial square root of
// PRICE_BITS+log2(MAX_WINDOW) bits (30 by default), makes three passes of the shared
// restoring divider with a quotient of PRICE_BITS+log2(MAX_WINDOW)+14 bits (44 by
// default; a pass whose divisor is zero is skipped, and so is the momentum pass while
// the series has fewer than four samples) and loads the result; the core returns to idle
// before the next request is taken. A short-series item goes from acceptance straight
// to the result load, with no walk and no arithmetic.
// Configuration writes are always taken (cfg_ready is high) and must only be issued while
// the core is idle.
module rolling_zscore_signal_core
    import rzs_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int PRICE_BITS = DEF_PRICE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input requests
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PRICE_BITS-1:0] price,
    input  logic                  series_start,
    // result requests
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            signal_code,
    output logic [15:0]           confidence,
    output logic signed [15:0]    z_score,
    output logic [15:0]           volatility,
    output logic [12:0]           position_fraction,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    localparam int LOGW = $clog2(MAX_WINDOW);
    localparam int NW   = LOGW + 1;              // holds MAX_WINDOW itself
    localparam int CW   = (NW > 7) ? NW : 7;     // window length compare width
    localparam int SUMW = PRICE_BITS + LOGW;     // window sum, also sqrt width
    localparam int SQW  = 2 * PRICE_BITS + LOGW; // sum of squares
    localparam int DW   = 2 * SUMW;              // variance term
    localparam int RW   = SUMW + 3;              // sqrt remainder
    localparam int SQCW = $clog2(SUMW);
    localparam int DVW  = SUMW + 14;             // divider dividend / quotient
    localparam int DSW  = SUMW;                  // divider divisor

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SS,
        S_DIFF,
        S_SQRT,
        S_ZST,
        S_ZWT,
        S_WST,
        S_WWT,
        S_MST,
        S_MWT,
        S_DECIDE
    } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    logic [LOGW-1:0]     ptr_reg;
    logic [NW-1:0]       count_reg;
    logic [6:0]          wl_reg;
    logic [14:0]         ez_reg;
    logic [14:0]         mz_reg;
    logic [15:0]         calm_reg;
    logic [15:0]         choppy_reg;
    logic [15:0]         mb_reg;

    // ring memory
    logic [PRICE_BITS-1:0] price_ring_reg [MAX_WINDOW];
    logic [PRICE_BITS-1:0] rd_data_reg;
    logic [LOGW-1:0]       rd_addr_reg;

    // datapath
    logic [PRICE_BITS-1:0] p_reg;
    logic                  short_reg;
    logic [NW-1:0]         rd_cnt_reg;
    logic                  v1_reg, acc1_reg, old1_reg;
    logic                  v2_reg, acc2_reg;
    logic [SUMW-1:0]       sum_reg;
    logic [SQW-1:0]        sumsq_reg;
    logic [2*SUMW-1:0]     mul_reg;
    logic [PRICE_BITS-1:0] old_reg;
    logic [DW-1:0]         d_reg;
    logic [RW-1:0]         rem_reg;
    logic [SUMW-1:0]       root_reg;
    logic [SQCW-1:0]       sq_cnt_reg;
    logic                  neg_reg;
    logic                  zneg_reg;
    logic [16:0]           zmag_reg;
    logic [16:0]           bw_reg;
    logic                  mneg_reg;
    logic [16:0]           mmag_reg;
    logic [1:0]            code_out_reg;
    logic [15:0]           conf_out_reg;
    logic [15:0]           z_out_reg;
    logic [15:0]           vol_out_reg;
    logic [12:0]           frac_out_reg;

    logic                  accept;
    logic                  out_free;
    logic [LOGW-1:0]       ptr_eff;
    logic [NW-1:0]         count_eff;
    logic [LOGW-1:0]       ptr_inc;
    logic [NW-1:0]         count_inc;
    logic [CW-1:0]         wl_ext;
    logic [NW-1:0]         n_win;
    logic [NW-1:0]         rd_total;
    logic                  mul_en;
    logic [SUMW-1:0]       mul_a, mul_b;
    logic [RW-1:0]         rem_sh;
    logic [RW-1:0]         trial;
    logic                  sq_ge;
    logic [SUMW:0]         num_diff;
    logic [SUMW-1:0]       num_mag;
    logic [PRICE_BITS:0]   mom_diff;
    logic [PRICE_BITS-1:0] mom_mag;
    logic                  mom_ok;
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [DVW-1:0]        div_dividend;
    logic [DSW-1:0]        div_divisor;
    logic [DVW-1:0]        div_quo;
    logic [16:0]           quo_sat;

    // decision
    logic [16:0]           ez17, mz17, mb17, calm17, choppy17;
    logic                  z_le_e, z_ge_e, z_le_m, z_ge_m;
    logic                  mom_gt_neg, mom_lt;
    logic                  bw_calm, bw_choppy;
    logic [18:0]           cz_wide;
    logic [15:0]           cz;
    sig_code_t             code;
    logic [15:0]           conf;
    logic [15:0]           frac_wide;
    logic [12:0]           frac_clamp;
    logic [12:0]           frac;
    logic [15:0]           z_out;
    logic [15:0]           vol_out;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = state_reg != S_IDLE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    // history position for this request
    assign ptr_eff   = series_start ? '0 : ptr_reg;
    assign count_eff = series_start ? '0 : count_reg;
    assign ptr_inc   = (ptr_eff == LOGW'(MAX_WINDOW - 1)) ? '0 : ptr_eff + 1'b1;
    assign count_inc = (count_eff < NW'(MAX_WINDOW)) ? count_eff + 1'b1 : count_eff;

    // effective window length
    always_comb
    begin
        wl_ext = CW'(wl_reg);
        if (wl_ext < CW'(2))
        begin
            n_win = NW'(2);
        end
        else if (wl_ext > CW'(MAX_WINDOW))
        begin
            n_win = NW'(MAX_WINDOW);
        end
        else
        begin
            n_win = NW'(wl_ext);
        end
    end

    // walk at least four entries so the momentum reference is picked up
    assign rd_total = (n_win < NW'(4)) ? NW'(4) : n_win;

    // shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = SUMW'(rd_data_reg);
        mul_b  = SUMW'(rd_data_reg);
        case (state_reg)
            S_READ, S_DRAIN:
            begin
                mul_en = v1_reg;
            end
            S_MUL_LO:
            begin
                mul_en = 1'b1;
                mul_a  = SUMW'(n_win);
                mul_b  = sumsq_reg[SUMW-1:0];
            end
            S_MUL_HI:
            begin
                mul_en = 1'b1;
                mul_a  = SUMW'(n_win);
                mul_b  = SUMW'(sumsq_reg[SQW-1:SUMW]);
            end
            S_MUL_SS:
            begin
                mul_en = 1'b1;
                mul_a  = sum_reg;
                mul_b  = sum_reg;
            end
            S_DIFF:
            begin
                mul_en = 1'b1;
                mul_a  = SUMW'(n_win);
                mul_b  = SUMW'(p_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // one root bit per cycle
    assign rem_sh = {rem_reg[RW-3:0], d_reg[DW-1:DW-2]};
    assign trial  = RW'({root_reg, 2'b01});
    assign sq_ge  = rem_sh >= trial;

    // numerator N*p - sum, split into sign and magnitude
    assign num_diff = {1'b0, mul_reg[SUMW-1:0]} - {1'b0, sum_reg};
    assign num_mag  = num_diff[SUMW] ? SUMW'(-num_diff) : num_diff[SUMW-1:0];

    // price change against three samples back
    assign mom_diff = {1'b0, p_reg} - {1'b0, old_reg};
    assign mom_mag  = mom_diff[PRICE_BITS] ? PRICE_BITS'(-mom_diff) : mom_diff[PRICE_BITS-1:0];
    assign mom_ok   = (count_reg >= NW'(4)) && (old_reg != '0);

    // divider feed
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DVW'({num_mag, 12'd0});
        div_divisor  = root_reg;
        case (state_reg)
            S_ZST:
            begin
                div_start = root_reg != '0;
            end
            S_WST:
            begin
                div_start    = sum_reg != '0;
                div_dividend = DVW'({root_reg, 14'd0});
                div_divisor  = sum_reg;
            end
            S_MST:
            begin
                div_start    = mom_ok;
                div_dividend = DVW'({mom_mag, 16'd0});
                div_divisor  = DSW'(old_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign quo_sat = (|div_quo[DVW-1:16]) ? 17'h10000 : {1'b0, div_quo[15:0]};

    rzs_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // signal decision on the unsaturated values (magnitudes clipped at 2^16)
    always_comb
    begin
        ez17     = {2'b0, ez_reg};
        mz17     = {2'b0, mz_reg};
        mb17     = {1'b0, mb_reg};
        calm17   = {1'b0, calm_reg};
        choppy17 = {1'b0, choppy_reg};

        z_le_e = (zneg_reg && zmag_reg >= ez17) || (zmag_reg == '0 && ez17 == '0);
        z_ge_e = !zneg_reg && zmag_reg >= ez17;
        z_le_m = (zneg_reg && zmag_reg >= mz17) || (zmag_reg == '0 && mz17 == '0);
        z_ge_m = !zneg_reg && zmag_reg >= mz17;

        mom_gt_neg = !((mneg_reg && mmag_reg >= mb17) || (mmag_reg == '0 && mb17 == '0));
        mom_lt     = !(!mneg_reg && mmag_reg >= mb17);

        bw_calm   = bw_reg < calm17;
        bw_choppy = bw_reg > choppy17;

        cz_wide = {zmag_reg, 2'b00};
        cz      = (cz_wide > 19'(CONF_CAP)) ? CONF_CAP : cz_wide[15:0];

        code = SIG_HOLD;
        conf = '0;
        if (z_le_e && mom_gt_neg)
        begin
            code = SIG_BUY;
            conf = cz;
        end
        else if (z_ge_e && mom_lt)
        begin
            code = SIG_SELL;
            conf = cz;
        end
        else if (z_le_m && bw_calm)
        begin
            code = SIG_BUY;
            conf = CONF_CALM;
        end
        else if (z_ge_m && bw_calm)
        begin
            code = SIG_SELL;
            conf = CONF_CALM;
        end

        // half-Kelly sizing
        frac_wide = conf - CONF_HALF;
        if (frac_wide < 16'(FRAC_MIN))
        begin
            frac_clamp = FRAC_MIN;
        end
        else if (frac_wide > 16'(FRAC_MAX))
        begin
            frac_clamp = FRAC_MAX;
        end
        else
        begin
            frac_clamp = frac_wide[12:0];
        end
        if (code != SIG_HOLD && conf > CONF_HALF)
        begin
            frac = bw_choppy ? (frac_clamp >> 1) : frac_clamp;
        end
        else
        begin
            frac = '0;
        end

        // output saturation
        if (zneg_reg)
        begin
            z_out = (zmag_reg > 17'd32768) ? 16'h8000 : 16'(~zmag_reg[15:0] + 16'd1);
        end
        else
        begin
            z_out = (zmag_reg > 17'd32767) ? 16'h7fff : zmag_reg[15:0];
        end
        vol_out = bw_reg[16] ? 16'hffff : bw_reg[15:0];
    end

    // sequencer, history pointers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            count_reg     <= '0;
            wl_reg        <= RST_WINDOW_LENGTH;
            ez_reg        <= RST_EXTREME_Z;
            mz_reg        <= RST_MODERATE_Z;
            calm_reg      <= RST_CALM_WIDTH;
            choppy_reg    <= RST_CHOPPY_WIDTH;
            mb_reg        <= RST_MOMENTUM_BAND;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH: wl_reg     <= cfg_data[6:0];
                    CFG_EXTREME_Z:     ez_reg     <= cfg_data[14:0];
                    CFG_MODERATE_Z:    mz_reg     <= cfg_data[14:0];
                    CFG_CALM_WIDTH:    calm_reg   <= cfg_data;
                    CFG_CHOPPY_WIDTH:  choppy_reg <= cfg_data;
                    CFG_MOMENTUM_BAND: mb_reg     <= cfg_data;
                    default:           ;
                endcase
            end

            // in S_DECIDE the result load below owns out_valid
            if (out_valid_reg && !out_stall && state_reg != S_DECIDE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ptr_reg   <= ptr_inc;
                        count_reg <= count_inc;
                        state_reg <= (count_inc < n_win) ? S_DECIDE : S_READ;
                    end
                end
                S_READ:
                begin
                    if (rd_cnt_reg == rd_total - 1'b1)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= S_MUL_LO;
                    end
                end
                S_MUL_LO: state_reg <= S_MUL_HI;
                S_MUL_HI: state_reg <= S_MUL_SS;
                S_MUL_SS: state_reg <= S_DIFF;
                S_DIFF:   state_reg <= S_SQRT;
                S_SQRT:
                begin
                    if (sq_cnt_reg == SQCW'(SUMW - 1))
                    begin
                        state_reg <= S_ZST;
                    end
                end
                S_ZST: state_reg <= div_start ? S_ZWT : S_WST;
                S_ZWT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_WST;
                    end
                end
                S_WST: state_reg <= div_start ? S_WWT : S_MST;
                S_WWT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MST;
                    end
                end
                S_MST: state_reg <= div_start ? S_MWT : S_DECIDE;
                S_MWT:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ring write on acceptance, registered read during the walk
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            price_ring_reg[ptr_eff] <= price;
        end
        rd_data_reg <= price_ring_reg[rd_addr_reg];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            mul_reg <= (2*SUMW)'(mul_a) * (2*SUMW)'(mul_b);
        end

        case (state_reg)
            S_IDLE:
            begin
                p_reg       <= price;
                short_reg   <= count_inc < n_win;
                rd_addr_reg <= ptr_eff;
                rd_cnt_reg  <= '0;
                sum_reg     <= '0;
                sumsq_reg   <= '0;
                v1_reg      <= 1'b0;
                v2_reg      <= 1'b0;
                acc1_reg    <= 1'b0;
                acc2_reg    <= 1'b0;
                old1_reg    <= 1'b0;
            end
            S_READ, S_DRAIN:
            begin
                // stage 0: issue address, newest first
                v1_reg   <= state_reg == S_READ;
                acc1_reg <= rd_cnt_reg < n_win;
                old1_reg <= rd_cnt_reg == NW'(3);
                if (state_reg == S_READ)
                begin
                    rd_cnt_reg  <= rd_cnt_reg + 1'b1;
                    rd_addr_reg <= (rd_addr_reg == '0) ? LOGW'(MAX_WINDOW - 1)
                                                      : rd_addr_reg - 1'b1;
                end
                // stage 1: data back, square in flight
                v2_reg   <= v1_reg;
                acc2_reg <= acc1_reg;
                if (v1_reg && acc1_reg)
                begin
                    sum_reg <= sum_reg + SUMW'(rd_data_reg);
                end
                if (v1_reg && old1_reg)
                begin
                    old_reg <= rd_data_reg;
                end
                // stage 2: accumulate the square
                if (v2_reg && acc2_reg)
                begin
                    sumsq_reg <= sumsq_reg + mul_reg[SQW-1:0];
                end
            end
            S_MUL_HI:
            begin
                d_reg <= mul_reg;
            end
            S_MUL_SS:
            begin
                d_reg <= d_reg + {mul_reg[SUMW-1:0], {SUMW{1'b0}}};
            end
            S_DIFF:
            begin
                d_reg      <= d_reg - mul_reg;
                rem_reg    <= '0;
                root_reg   <= '0;
                sq_cnt_reg <= '0;
            end
            S_SQRT:
            begin
                d_reg      <= {d_reg[DW-3:0], 2'b00};
                sq_cnt_reg <= sq_cnt_reg + 1'b1;
                root_reg   <= {root_reg[SUMW-2:0], sq_ge};
                rem_reg    <= sq_ge ? rem_sh - trial : rem_sh;
            end
            S_ZST:
            begin
                neg_reg  <= num_diff[SUMW];
                zneg_reg <= 1'b0;
                zmag_reg <= '0;
            end
            S_ZWT:
            begin
                if (div_done)
                begin
                    zmag_reg <= quo_sat;
                    zneg_reg <= neg_reg && (quo_sat != '0);
                end
            end
            S_WST:
            begin
                bw_reg <= '0;
            end
            S_WWT:
            begin
                if (div_done)
                begin
                    bw_reg <= quo_sat;
                end
            end
            S_MST:
            begin
                neg_reg  <= mom_diff[PRICE_BITS];
                mneg_reg <= 1'b0;
                mmag_reg <= '0;
            end
            S_MWT:
            begin
                if (div_done)
                begin
                    mmag_reg <= quo_sat;
                    mneg_reg <= neg_reg && (quo_sat != '0);
                end
            end
            S_DECIDE:
            begin
                if (out_free)
                begin
                    if (short_reg)
                    begin
                        code_out_reg <= SIG_HOLD;
                        conf_out_reg <= '0;
                        z_out_reg    <= '0;
                        vol_out_reg  <= '0;
                        frac_out_reg <= '0;
                    end
                    else
                    begin
                        code_out_reg <= code;
                        conf_out_reg <= conf;
                        z_out_reg    <= z_out;
                        vol_out_reg  <= vol_out;
                        frac_out_reg <= frac;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid         = out_valid_reg;
    assign signal_code       = code_out_reg;
    assign confidence        = conf_out_reg;
    assign z_score           = z_out_reg;
    assign volatility        = vol_out_reg;
    assign position_fraction = frac_out_reg;

`ifndef SYNTH
    // the divider is never restarted while it still works on a quotient
    assert property (@(posedge clk) disable iff (!rst_n) div_start |-> !div_busy)
        else $error("divider started while busy");

    // a position is only taken alongside a buy or sell
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && signal_code == SIG_HOLD) |-> position_fraction == '0)
        else $error("position on hold result");

    // confidence is capped
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> confidence <= CONF_CAP)
        else $error("confidence above cap");

    // a new result is only loaded once the previous one has been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && out_valid_reg && out_stall) |=> state_reg == S_DECIDE)
        else $error("result overwritten");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rzs_pkg::*;

    typedef struct packed {
        logic [1:0]         code;
        logic [15:0]        conf;
        logic signed [15:0] z;
        logic [15:0]        vol;
        logic [12:0]        frac;
    } signal_result_t;

    logic clk;
    logic rst_n;

    // input request channel
    logic        in_valid;
    logic        in_stall;
    logic [23:0] price;
    logic        series_start;

    // result request channel
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         signal_code;
    logic [15:0]        confidence;
    logic signed [15:0] z_score;
    logic [15:0]        volatility;
    logic [12:0]        position_fraction;

    // register write channel
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    rolling_zscore_signal_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .price             (price),
        .series_start      (series_start),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .signal_code       (signal_code),
        .confidence        (confidence),
        .z_score           (z_score),
        .volatility        (volatility),
        .position_fraction (position_fraction),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // predictor copy of the core state and registers
    logic [23:0] hist_ring [0:63];
    int          hist_ptr;
    int          hist_count;
    int          win_len;
    int          ext_z;
    int          mod_z;
    int          calm_w;
    int          choppy_w;
    int          mom_band;

    // signals still owed by the core, oldest first
    signal_result_t pending_signals[$];
    int             errors;

    // idling control
    bit quiet;       // no idling in the final part
    bit hold_long;   // receiver holds off for a long stretch
    int stall_left;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // update the history and queue the signal this sample should produce
    task automatic predict_signal(input logic [23:0] p, input logic st);
        signal_result_t r;
        int     n;
        longint sum, sq, d, s, num, zq, bw, mom, old, az, cz, frac;
        if (st)
        begin
            hist_ptr   = 0;
            hist_count = 0;
        end
        hist_ring[hist_ptr] = p;
        hist_ptr = (hist_ptr + 1) % 64;
        if (hist_count < 64)
            hist_count++;
        n = win_len < 2 ? 2 : (win_len > 64 ? 64 : win_len);
        r = '0;
        if (hist_count >= n)
        begin
            sum = 0;
            sq  = 0;
            for (int i = 1; i <= n; i++)
            begin
                old = hist_ring[(hist_ptr + 64 - i) % 64];
                sum += old;
                sq  += old * old;
            end
            d   = n * sq - sum * sum;
            s   = longint'(floor_sqrt(d));
            zq  = 0;
            bw  = 0;
            mom = 0;
            if (s != 0)
            begin
                num = n * longint'(p) - sum;
                zq  = (num * 4096) / s;
            end
            if (sum != 0)
                bw = (s << 14) / sum;
            if (hist_count >= 4)
            begin
                old = hist_ring[(hist_ptr + 60) % 64];
                if (old != 0)
                    mom = ((longint'(p) - old) * 65536) / old;
            end
            az = zq < 0 ? -zq : zq;
            cz = az * 4;
            if (cz > CONF_CAP)
                cz = CONF_CAP;
            r.code = SIG_HOLD;
            if (zq <= -ext_z && mom > -mom_band)
            begin
                r.code = SIG_BUY;
                r.conf = cz[15:0];
            end
            else if (zq >= ext_z && mom < mom_band)
            begin
                r.code = SIG_SELL;
                r.conf = cz[15:0];
            end
            else if (zq <= -mod_z && bw < calm_w)
            begin
                r.code = SIG_BUY;
                r.conf = CONF_CALM;
            end
            else if (zq >= mod_z && bw < calm_w)
            begin
                r.code = SIG_SELL;
                r.conf = CONF_CALM;
            end
            if (r.code != SIG_HOLD && r.conf > CONF_HALF)
            begin
                frac = r.conf - CONF_HALF;
                if (frac < FRAC_MIN)
                    frac = FRAC_MIN;
                if (frac > FRAC_MAX)
                    frac = FRAC_MAX;
                if (bw > choppy_w)
                    frac >>= 1;
                r.frac = frac[12:0];
            end
            r.z   = zq > 32767 ? 16'h7FFF : (zq < -32768 ? 16'h8000 : zq[15:0]);
            r.vol = bw > 65535 ? 16'hFFFF : bw[15:0];
        end
        pending_signals = {pending_signals, r};
    endtask

    // send one price request, with an optional random gap first
    task automatic send_price(input logic [23:0] p, input logic st);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        price        <= p;
        series_start <= st;
        do
            @(posedge clk);
        while (in_stall);
        predict_signal(p, st);
        @(negedge clk);
    endtask

    // stop offering and wait for every owed signal, then let the core settle
    task automatic drain_signals();
        in_valid <= 1'b0;
        while (pending_signals.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_WINDOW_LENGTH: win_len  = val[6:0];
            CFG_EXTREME_Z:     ext_z    = val[14:0];
            CFG_MODERATE_Z:    mod_z    = val[14:0];
            CFG_CALM_WIDTH:    calm_w   = val;
            CFG_CHOPPY_WIDTH:  choppy_w = val;
            CFG_MOMENTUM_BAND: mom_band = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_regs(input int w, input int ez, input int mz,
                                  input int cw, input int chw, input int mb);
        write_reg(CFG_WINDOW_LENGTH, 16'(w));
        write_reg(CFG_EXTREME_Z, 16'(ez));
        write_reg(CFG_MODERATE_Z, 16'(mz));
        write_reg(CFG_CALM_WIDTH, 16'(cw));
        write_reg(CFG_CHOPPY_WIDTH, 16'(chw));
        write_reg(CFG_MOMENTUM_BAND, 16'(mb));
    endtask

    function automatic logic [23:0] clamp_price(input longint v);
        return v < 1 ? 24'd1 : (v > 24'hFFFFFF ? 24'hFFFFFF : v[23:0]);
    endfunction

    // mostly quiet series around a base price with spikes, plus some raw noise
    task automatic send_random_series(input int items);
        longint base, step, v;
        int     left;
        left = 0;
        for (int k = 0; k < items; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_price(24'($urandom_range(1, 24'hFFFFFF)), 1'($urandom_range(0, 1)));
            else
            begin
                if (left == 0)
                begin
                    base = $urandom_range(0, 3) == 0 ? $urandom_range(1, 24'hFFFFFF)
                                                     : $urandom_range(100, 2000000);
                    left = $urandom_range(4, 80);
                end
                step = base / 200 + 1;
                v = base + longint'($urandom_range(0, 2 * step)) - step;
                if ($urandom_range(0, 7) == 0)
                    v = base + ($urandom_range(0, 1) ? 1 : -1) * step * $urandom_range(4, 20);
                send_price(clamp_price(v), left == 80 || k == 0 || left == 0);
                left--;
                if (left < 0)
                    left = 0;
            end
        end
    endtask

    // extremes of price, short series, flat window, spikes both ways
    task automatic test_directed();
        write_all_regs(2, RST_EXTREME_Z, RST_MODERATE_Z, RST_CALM_WIDTH,
                       RST_CHOPPY_WIDTH, RST_MOMENTUM_BAND);
        send_price(24'd1, 1'b1);
        send_price(24'hFFFFFF, 1'b0);
        send_price(24'hFFFFFF, 1'b0);
        send_price(24'd1, 1'b0);
        send_price(24'd1, 1'b0);
        send_price(24'hFFFFFF, 1'b1);
        send_price(24'h800000, 1'b0);
        drain_signals();
        write_reg(CFG_WINDOW_LENGTH, 16'd4);
        send_price(24'd1000000, 1'b1);
        send_price(24'd1000000, 1'b0);
        send_price(24'd1000000, 1'b0);
        send_price(24'd1000000, 1'b0);
        send_price(24'd1000100, 1'b0);
        send_price(24'd999900, 1'b0);
        send_price(24'd1000000, 1'b0);
        send_price(24'd990000, 1'b0);
        send_price(24'd1010000, 1'b0);
        send_price(24'd1000000, 1'b0);
        send_price(24'd1000010, 1'b0);
        send_price(24'd999990, 1'b0);
        drain_signals();
        // window below 2 and above the ring size
        write_reg(CFG_WINDOW_LENGTH, 16'd0);
        send_price(24'd500, 1'b1);
        send_price(24'd700, 1'b0);
        drain_signals();
        write_reg(CFG_WINDOW_LENGTH, 16'd127);
        send_price(24'd300, 1'b1);
        send_price(24'd301, 1'b0);
        drain_signals();
    endtask

    // several register settings, extremes among them
    task automatic test_random_settings();
        int w;
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: write_all_regs(64, 0, 0, 0, 0, 0);
                1: write_all_regs(2, 32767, 32767, 65535, 65535, 65535);
                2: write_all_regs(RST_WINDOW_LENGTH, RST_EXTREME_Z, RST_MODERATE_Z,
                                  RST_CALM_WIDTH, RST_CHOPPY_WIDTH, RST_MOMENTUM_BAND);
                3: write_all_regs(1, 4096, 2048, 65535, 0, 0);
                default:
                begin
                    w = $urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                  : $urandom_range(2, 12);
                    write_all_regs(w, $urandom_range(0, 16000), $urandom_range(0, 10000),
                                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                             : $urandom_range(20, 400),
                                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                             : $urandom_range(20, 400),
                                   $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535)
                                                             : $urandom_range(100, 3000));
                end
            endcase
            send_random_series(ph < 2 ? 40 : 95);
            drain_signals();
        end
    endtask

    // receiver holds off while requests keep coming, so the core backs up
    task automatic test_backpressure();
        write_all_regs(3, RST_EXTREME_Z, RST_MODERATE_Z, RST_CALM_WIDTH,
                       RST_CHOPPY_WIDTH, RST_MOMENTUM_BAND);
        fork
            begin
                hold_long = 1'b1;
                repeat (600) @(negedge clk);
                hold_long = 1'b0;
            end
            send_random_series(30);
        join
        drain_signals();
    endtask

    // last part with no idling on either side
    task automatic test_full_rate();
        quiet = 1'b1;
        write_all_regs(5, RST_EXTREME_Z, RST_MODERATE_Z, RST_CALM_WIDTH,
                       RST_CHOPPY_WIDTH, RST_MOMENTUM_BAND);
        send_random_series(60);
        drain_signals();
    endtask

    // receiver stall: random bursts, a long hold-off, none at the end
    always @(negedge clk)
    begin
        if (hold_long)
            out_stall <= 1'b1;
        else if (quiet)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 6);
        end
        else
            out_stall <= 1'b0;
    end

    // compare each accepted result with the oldest owed signal
    always @(posedge clk)
    begin
        signal_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_signals.size() == 0)
            begin
                $display("%0t unexpected result code %0d", $time, signal_code);
                errors++;
            end
            else
            begin
                e = pending_signals.pop_front();
                if (signal_code !== e.code)
                begin
                    $display("%0t signal_code exp %0d act %0d", $time, e.code, signal_code);
                    errors++;
                end
                if (confidence !== e.conf)
                begin
                    $display("%0t confidence exp %0d act %0d", $time, e.conf, confidence);
                    errors++;
                end
                if (z_score !== e.z)
                begin
                    $display("%0t z_score exp %0d act %0d", $time, e.z, z_score);
                    errors++;
                end
                if (volatility !== e.vol)
                begin
                    $display("%0t volatility exp %0d act %0d", $time, e.vol, volatility);
                    errors++;
                end
                if (position_fraction !== e.frac)
                begin
                    $display("%0t position_fraction exp %0d act %0d", $time, e.frac,
                             position_fraction);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        price        = '0;
        series_start = 1'b0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        quiet        = 1'b0;
        hold_long    = 1'b0;
        stall_left   = 0;
        errors       = 0;
        hist_ptr     = 0;
        hist_count   = 0;
        win_len      = RST_WINDOW_LENGTH;
        ext_z        = RST_EXTREME_Z;
        mod_z        = RST_MODERATE_Z;
        calm_w       = RST_CALM_WIDTH;
        choppy_w     = RST_CHOPPY_WIDTH;
        mom_band     = RST_MOMENTUM_BAND;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random_settings();
        test_backpressure();
        test_full_rate();

        repeat (300) @(negedge clk);
        if (errors == 0 && pending_signals.size() == 0)
            $display("testbench: PASS");
        else
        begin
            if (pending_signals.size() != 0)
                $display("%0t %0d results never arrived", $time, pending_signals.size());
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
